// File: hdl/cau_pkg.sv
// shared types and constants of the complex arithmetic unit
// no dependencies
package cau_pkg;

	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_SAT = 2'd1,
		ST_DZ  = 2'd2
	} status_t;

	typedef struct packed {
		logic valid;
		logic is_div;
		logic dz;
		logic neg_re;
		logic neg_im;
		logic ovf_re;
		logic ovf_im;
		logic sat;
	} ctl_t;

endpackage

// File: hdl/cau_if.sv
// item channels of the complex arithmetic unit: operand request and result
// depends on cau_pkg
interface cau_req_if import cau_pkg::*; #(parameter int DATA_WIDTH = DATA_WIDTH_DEF);
	logic                         valid;
	logic                         ready;
	op_t                          opcode;
	logic signed [DATA_WIDTH-1:0] a_re;
	logic signed [DATA_WIDTH-1:0] a_im;
	logic signed [DATA_WIDTH-1:0] b_re;
	logic signed [DATA_WIDTH-1:0] b_im;

	modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
	modport sink (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_rsp_if import cau_pkg::*; #(parameter int DATA_WIDTH = DATA_WIDTH_DEF);
	logic                         valid;
	logic                         ready;
	logic signed [DATA_WIDTH-1:0] r_re;
	logic signed [DATA_WIDTH-1:0] r_im;
	status_t                      status;

	modport source (output valid, r_re, r_im, status, input ready);
	modport sink (input valid, r_re, r_im, status, output ready);
endinterface

// File: hdl/complex_arithmetic_unit.sv
// complex arithmetic unit top level: add, subtract, multiply, divide in fixed point
// depends on cau_pkg, cau_req_if, cau_rsp_if, cau_div_stage
//
// usage:
//   req carries opcode and operands a, b; rsp returns r_re, r_im and status
//   an item is taken when valid and ready are both high on a rising edge
//   an item passes from acceptance to rsp.valid through four front stages,
//   the quotient stages, one quotient bit each, and one output register
//   one item per cycle is accepted while rsp keeps ready high
//   divide uses DATA_WIDTH quotient stages, one restoring step each
//   arst_n clears all valid bits; nothing is in flight after reset
//   when rsp stalls with a result waiting, the whole pipeline holds
//   and req.ready drops; no item is lost or repeated
//   status: ok, saturated when either part clamps, divide by zero
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	cau_req_if.sink   req,
	cau_rsp_if.source rsp
);

	localparam int DW = DATA_WIDTH;
	localparam int WW = 2 * DW + 1;
	localparam int RW = 3 * DW + FRAC_BITS + 1;
	localparam logic [DW-1:0] MAXV = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] MINV = {1'b1, {(DW-1){1'b0}}};

	logic en;
	logic out_valid_q;

	assign en        = !out_valid_q || rsp.ready;
	assign req.ready = en;

	// stage 1: operand register
	logic                 v_s1;
	op_t                  op_s1;
	logic signed [DW-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	// stage 2: products, and sums or differences for add and subtract
	logic                   v_s2;
	op_t                    op_s2;
	logic signed [2*DW-1:0] p_rr_s2, p_ii_s2, p_ri_s2, p_ir_s2, p_bbr_s2, p_bbi_s2;
	logic signed [DW:0]     sum_re_s2, sum_im_s2;

	// stage 3: sums and differences of products, divisor, add and subtract results
	logic                 v_s3;
	op_t                  op_s3;
	logic signed [WW-1:0] ws_re_s3, ws_im_s3;
	logic [2*DW-1:0]      den_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= req.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= req.opcode;
			ar_s1 <= req.a_re;
			ai_s1 <= req.a_im;
			br_s1 <= req.b_re;
			bi_s1 <= req.b_im;

			op_s2    <= op_s1;
			p_rr_s2  <= ar_s1 * br_s1;
			p_ii_s2  <= ai_s1 * bi_s1;
			p_ri_s2  <= ar_s1 * bi_s1;
			p_ir_s2  <= ai_s1 * br_s1;
			p_bbr_s2 <= br_s1 * br_s1;
			p_bbi_s2 <= bi_s1 * bi_s1;
			if (op_s1 == OP_SUB) begin
				sum_re_s2 <= (DW+1)'(ar_s1) - (DW+1)'(br_s1);
				sum_im_s2 <= (DW+1)'(ai_s1) - (DW+1)'(bi_s1);
			end else begin
				sum_re_s2 <= (DW+1)'(ar_s1) + (DW+1)'(br_s1);
				sum_im_s2 <= (DW+1)'(ai_s1) + (DW+1)'(bi_s1);
			end

			op_s3  <= op_s2;
			den_s3 <= $unsigned(p_bbr_s2) + $unsigned(p_bbi_s2);
			case (op_s2)
				OP_MUL: begin
					ws_re_s3 <= WW'(p_rr_s2) - WW'(p_ii_s2);
					ws_im_s3 <= WW'(p_ri_s2) + WW'(p_ir_s2);
				end
				OP_DIV: begin
					ws_re_s3 <= WW'(p_rr_s2) + WW'(p_ii_s2);
					ws_im_s3 <= WW'(p_ir_s2) - WW'(p_ri_s2);
				end
				default: begin
					ws_re_s3 <= WW'(sum_re_s2);
					ws_im_s3 <= WW'(sum_im_s2);
				end
			endcase
		end
	end

	// stage 4: scaling, saturation of non-divide results, divide setup
	function automatic logic [DW:0] sat_fn(input logic signed [WW-1:0] v);
		logic fits;
		fits = (&v[WW-1:DW-1]) || !(|v[WW-1:DW-1]);
		return fits ? {1'b0, v[DW-1:0]} : {1'b1, (v[WW-1] ? MINV : MAXV)};
	endfunction

	logic signed [WW-1:0] val_re, val_im;
	logic [DW:0]          st_re, st_im;
	logic [WW-1:0]        mag_re, mag_im;
	logic [RW-1:0]        rem_re, rem_im, dlim;
	ctl_t                 ctl_4;

	always_comb begin
		val_re = (op_s3 == OP_MUL) ? (ws_re_s3 >>> FRAC_BITS) : ws_re_s3;
		val_im = (op_s3 == OP_MUL) ? (ws_im_s3 >>> FRAC_BITS) : ws_im_s3;
		st_re  = sat_fn(val_re);
		st_im  = sat_fn(val_im);
		mag_re = ws_re_s3[WW-1] ? $unsigned(-ws_re_s3) : $unsigned(ws_re_s3);
		mag_im = ws_im_s3[WW-1] ? $unsigned(-ws_im_s3) : $unsigned(ws_im_s3);
		rem_re = RW'(mag_re) << FRAC_BITS;
		rem_im = RW'(mag_im) << FRAC_BITS;
		dlim   = RW'(den_s3) << DW;
		ctl_4.valid  = v_s3;
		ctl_4.is_div = (op_s3 == OP_DIV);
		ctl_4.dz     = (op_s3 == OP_DIV) && (den_s3 == '0);
		ctl_4.neg_re = ws_re_s3[WW-1];
		ctl_4.neg_im = ws_im_s3[WW-1];
		ctl_4.ovf_re = (rem_re >= dlim);
		ctl_4.ovf_im = (rem_im >= dlim);
		ctl_4.sat    = st_re[DW] || st_im[DW];
	end

	ctl_t            ctl_s4;
	logic [2*DW-1:0] den_s4;
	logic [RW-1:0]   rem_re_s4, rem_im_s4;
	logic [DW-1:0]   q_re_s4, q_im_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s4 <= ctl_4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s4    <= den_s3;
			rem_re_s4 <= rem_re;
			rem_im_s4 <= rem_im;
			q_re_s4   <= (op_s3 == OP_DIV) ? '0 : st_re[DW-1:0];
			q_im_s4   <= (op_s3 == OP_DIV) ? '0 : st_im[DW-1:0];
		end
	end

	// quotient stages, most significant bit first
	ctl_t            ctl_c [0:DW];
	logic [2*DW-1:0] den_c [0:DW];
	logic [RW-1:0]   rre_c [0:DW];
	logic [RW-1:0]   rim_c [0:DW];
	logic [DW-1:0]   qre_c [0:DW];
	logic [DW-1:0]   qim_c [0:DW];

	assign ctl_c[0] = ctl_s4;
	assign den_c[0] = den_s4;
	assign rre_c[0] = rem_re_s4;
	assign rim_c[0] = rem_im_s4;
	assign qre_c[0] = q_re_s4;
	assign qim_c[0] = q_im_s4;

	for (genvar k = 0; k < DW; k++) begin : g_div
		cau_div_stage #(
			.DATA_WIDTH (DW),
			.REM_WIDTH  (RW),
			.SHIFT      (DW - 1 - k)
		) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.ctl_i    (ctl_c[k]),
			.den_i    (den_c[k]),
			.rem_re_i (rre_c[k]),
			.rem_im_i (rim_c[k]),
			.q_re_i   (qre_c[k]),
			.q_im_i   (qim_c[k]),
			.ctl_o    (ctl_c[k+1]),
			.den_o    (den_c[k+1]),
			.rem_re_o (rre_c[k+1]),
			.rem_im_o (rim_c[k+1]),
			.q_re_o   (qre_c[k+1]),
			.q_im_o   (qim_c[k+1])
		);
	end

	// sign and saturation of the quotient, output register
	function automatic logic [DW:0] qfix_fn(input logic [DW-1:0] q, input logic neg,
			input logic ovf);
		logic [DW:0] r;
		if (!neg) begin
			r = (ovf || q[DW-1]) ? {1'b1, MAXV} : {1'b0, q};
		end else begin
			r = (ovf || (q > MINV)) ? {1'b1, MINV} : {1'b0, DW'(-q)};
		end
		return r;
	endfunction

	ctl_t        ctl_f;
	logic [DW:0] f_re, f_im;
	logic [DW-1:0] r_re_q, r_im_q;
	status_t     status_q;

	always_comb begin
		ctl_f = ctl_c[DW];
		if (ctl_f.is_div) begin
			f_re = qfix_fn(qre_c[DW], ctl_f.neg_re, ctl_f.ovf_re);
			f_im = qfix_fn(qim_c[DW], ctl_f.neg_im, ctl_f.ovf_im);
		end else begin
			f_re = {ctl_f.sat, qre_c[DW]};
			f_im = {1'b0, qim_c[DW]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_f.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (ctl_f.dz) begin
				r_re_q   <= '0;
				r_im_q   <= '0;
				status_q <= ST_DZ;
			end else begin
				r_re_q   <= f_re[DW-1:0];
				r_im_q   <= f_im[DW-1:0];
				status_q <= (f_re[DW] || f_im[DW]) ? ST_SAT : ST_OK;
			end
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.r_re   = r_re_q;
	assign rsp.r_im   = r_im_q;
	assign rsp.status = status_q;

	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_DZ |-> rsp.r_re == '0 && rsp.r_im == '0)
		else $error("divide by zero result not zero");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready == (!rsp.valid || rsp.ready))
		else $error("ready does not follow output stall");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status == ST_SAT |->
		rsp.r_re == MAXV || rsp.r_re == MINV || rsp.r_im == MAXV || rsp.r_im == MINV)
		else $error("saturated status without a clamped part");

	a_dz_div: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s4.valid && ctl_s4.dz |-> ctl_s4.is_div)
		else $error("zero divisor flag on a non-divide item");

endmodule

// File: hdl/cau_div_stage.sv
// one registered restoring step of the two-lane quotient pipeline
// depends on cau_pkg
module cau_div_stage import cau_pkg::*; #(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int REM_WIDTH  = 3 * DATA_WIDTH_DEF + FRAC_BITS_DEF + 1,
	parameter int SHIFT      = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  ctl_t                      ctl_i,
	input  logic [2*DATA_WIDTH-1:0]   den_i,
	input  logic [REM_WIDTH-1:0]      rem_re_i,
	input  logic [REM_WIDTH-1:0]      rem_im_i,
	input  logic [DATA_WIDTH-1:0]     q_re_i,
	input  logic [DATA_WIDTH-1:0]     q_im_i,
	output ctl_t                      ctl_o,
	output logic [2*DATA_WIDTH-1:0]   den_o,
	output logic [REM_WIDTH-1:0]      rem_re_o,
	output logic [REM_WIDTH-1:0]      rem_im_o,
	output logic [DATA_WIDTH-1:0]     q_re_o,
	output logic [DATA_WIDTH-1:0]     q_im_o
);

	ctl_t                    ctl_s1;
	logic [2*DATA_WIDTH-1:0] den_s1;
	logic [REM_WIDTH-1:0]    rem_re_s1, rem_im_s1;
	logic [DATA_WIDTH-1:0]   q_re_s1, q_im_s1;

	logic [REM_WIDTH-1:0] dsh;
	logic [REM_WIDTH:0]   diff_re, diff_im;
	logic                 take_re, take_im;

	always_comb begin
		dsh     = REM_WIDTH'(den_i) << SHIFT;
		diff_re = {1'b0, rem_re_i} - {1'b0, dsh};
		diff_im = {1'b0, rem_im_i} - {1'b0, dsh};
		take_re = ctl_i.is_div && !diff_re[REM_WIDTH];
		take_im = ctl_i.is_div && !diff_im[REM_WIDTH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s1    <= den_i;
			rem_re_s1 <= take_re ? diff_re[REM_WIDTH-1:0] : rem_re_i;
			rem_im_s1 <= take_im ? diff_im[REM_WIDTH-1:0] : rem_im_i;
			q_re_s1   <= q_re_i | (take_re ? (DATA_WIDTH'(1) << SHIFT) : '0);
			q_im_s1   <= q_im_i | (take_im ? (DATA_WIDTH'(1) << SHIFT) : '0);
		end
	end

	assign ctl_o    = ctl_s1;
	assign den_o    = den_s1;
	assign rem_re_o = rem_re_s1;
	assign rem_im_o = rem_im_s1;
	assign q_re_o   = q_re_s1;
	assign q_im_o   = q_im_s1;

endmodule
